### sv/tlb_lf_pkg.sv
package tlb_lf_pkg;

    localparam int ENTRIES_DEF    = 16;
    localparam int PAGE_BITS_DEF  = 20;
    localparam int FRAME_BITS_DEF = 20;
    localparam int COUNT_BITS_DEF = 8;

    localparam int             CFG_W     = 5;
    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_FILL   = 1'b1;

    typedef struct packed {
        logic vld;
        logic cmd;
        logic wr;
        logic found;
        logic free_found;
    } tok_ctrl_t;

    typedef struct packed {
        logic en;
        logic cmd;
        logic wr;
    } commit_t;

endpackage

### sv/tlb_lf_cell.sv
module tlb_lf_cell #(
    parameter int IDX        = 0,
    parameter int ENTRIES    = tlb_lf_pkg::ENTRIES_DEF,
    parameter int PAGE_BITS  = tlb_lf_pkg::PAGE_BITS_DEF,
    parameter int FRAME_BITS = tlb_lf_pkg::FRAME_BITS_DEF,
    parameter int COUNT_BITS = tlb_lf_pkg::COUNT_BITS_DEF,
    localparam int IDX_W     = $clog2(ENTRIES),
    localparam int CNT_W     = $clog2(ENTRIES + 1)
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [CNT_W-1:0]       n_active,
    input  tlb_lf_pkg::tok_ctrl_t  in_ctrl,
    input  logic [PAGE_BITS-1:0]   in_page,
    input  logic [FRAME_BITS-1:0]  in_frame,
    input  logic [IDX_W-1:0]       in_slot,
    input  logic [COUNT_BITS-1:0]  in_low,
    output tlb_lf_pkg::tok_ctrl_t  out_ctrl,
    output logic [PAGE_BITS-1:0]   out_page,
    output logic [FRAME_BITS-1:0]  out_frame,
    output logic [IDX_W-1:0]       out_slot,
    output logic [COUNT_BITS-1:0]  out_low,
    input  tlb_lf_pkg::commit_t    commit,
    input  logic [IDX_W-1:0]       commit_slot,
    input  logic [PAGE_BITS-1:0]   commit_page,
    input  logic [FRAME_BITS-1:0]  commit_frame
);

    localparam logic [IDX_W-1:0]      MY_IDX    = IDX_W'(IDX);
    localparam logic [CNT_W-1:0]      MY_POS    = CNT_W'(IDX);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    logic                  valid_reg, valid_next;
    logic                  dirty_reg, dirty_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic [PAGE_BITS-1:0]  page_reg;
    logic [FRAME_BITS-1:0] frame_reg;

    tlb_lf_pkg::tok_ctrl_t tok_ctrl_reg, tok_ctrl_next;
    logic [PAGE_BITS-1:0]  tok_page_reg;
    logic [FRAME_BITS-1:0] tok_frame_reg, tok_frame_next;
    logic [IDX_W-1:0]      tok_slot_reg, tok_slot_next;
    logic [COUNT_BITS-1:0] tok_low_reg, tok_low_next;

    logic active;
    logic write_me;

    assign active   = MY_POS < n_active;
    assign write_me = commit.en && (commit_slot == MY_IDX);

    // Search step: lookups take the first valid match, fills the first free
    // entry or else the first entry holding the lowest use count.
    always_comb
    begin
        tok_ctrl_next  = in_ctrl;
        tok_frame_next = in_frame;
        tok_slot_next  = in_slot;
        tok_low_next   = in_low;
        if (in_ctrl.vld && active)
        begin
            if (in_ctrl.cmd == tlb_lf_pkg::CMD_LOOKUP)
            begin
                if (!in_ctrl.found && valid_reg && (page_reg == in_page))
                begin
                    tok_ctrl_next.found = 1'b1;
                    tok_frame_next      = frame_reg;
                    tok_slot_next       = MY_IDX;
                end
            end
            else if (!in_ctrl.free_found)
            begin
                if (!valid_reg)
                begin
                    tok_ctrl_next.free_found = 1'b1;
                    tok_slot_next            = MY_IDX;
                end
                else if (count_reg < in_low)
                begin
                    tok_low_next  = count_reg;
                    tok_slot_next = MY_IDX;
                end
            end
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        dirty_next = dirty_reg;
        count_next = count_reg;
        if (write_me)
        begin
            if (commit.cmd == tlb_lf_pkg::CMD_FILL)
            begin
                valid_next = 1'b1;
                dirty_next = commit.wr;
                count_next = '0;
            end
            else
            begin
                dirty_next = dirty_reg | commit.wr;
                if (count_reg != COUNT_MAX)
                begin
                    count_next = count_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= 1'b0;
            dirty_reg    <= 1'b0;
            count_reg    <= '0;
            tok_ctrl_reg <= '0;
        end
        else
        begin
            valid_reg    <= valid_next;
            dirty_reg    <= dirty_next;
            count_reg    <= count_next;
            tok_ctrl_reg <= tok_ctrl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tok_page_reg  <= in_page;
        tok_frame_reg <= tok_frame_next;
        tok_slot_reg  <= tok_slot_next;
        tok_low_reg   <= tok_low_next;
        if (write_me && (commit.cmd == tlb_lf_pkg::CMD_FILL))
        begin
            page_reg  <= commit_page;
            frame_reg <= commit_frame;
        end
    end

    assign out_ctrl  = tok_ctrl_reg;
    assign out_page  = tok_page_reg;
    assign out_frame = tok_frame_reg;
    assign out_slot  = tok_slot_reg;
    assign out_low   = tok_low_reg;

endmodule

### sv/tlb_lookup_fill_lfu.sv
// Fully associative translation buffer with least-frequently-used replacement. Each entry
// lives in one cell of a chain, and a request travels down the chain one cell per cycle,
// so a new request is not accepted until the one before it has passed the whole chain and
// its result has been registered for the output. A lookup (tuser 0) returns the frame of
// the lowest-index valid match and raises its use count; a fill (tuser 1) installs the page
// in the first free entry, or else in the first entry with the lowest use count. The entry
// count register must be written only while no request is in flight; the block itself does
// not enforce this. A value of 0 acts as 1 and one above ENTRIES acts as ENTRIES.
module tlb_lookup_fill_lfu #(
    parameter int ENTRIES    = tlb_lf_pkg::ENTRIES_DEF,
    parameter int PAGE_BITS  = tlb_lf_pkg::PAGE_BITS_DEF,
    parameter int FRAME_BITS = tlb_lf_pkg::FRAME_BITS_DEF,
    parameter int COUNT_BITS = tlb_lf_pkg::COUNT_BITS_DEF,
    localparam int IDX_W     = $clog2(ENTRIES),
    localparam int IN_RAW    = PAGE_BITS + 1 + FRAME_BITS,
    localparam int IN_W      = ((IN_RAW + 7) / 8) * 8,
    localparam int OUT_RAW   = 1 + FRAME_BITS + IDX_W + 1 + 32,
    localparam int OUT_W     = ((OUT_RAW + 7) / 8) * 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [tlb_lf_pkg::CFG_W-1:0]  cfg_wdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // page_number, is_write, fill_frame
    input  logic [IN_W-1:0]               s_tdata,
    // command
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // hit, frame, slot, replaced_valid, hits_so_far
    output logic [OUT_W-1:0]              m_tdata
);

    localparam int CNT_W = $clog2(ENTRIES + 1);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SWEEP  = 2'd1;
    localparam logic [1:0] ST_COMMIT = 2'd2;

    logic [1:0] state_reg, state_next;

    logic [tlb_lf_pkg::CFG_W-1:0] cfg_reg;
    logic [CNT_W-1:0]             n_active;

    tlb_lf_pkg::tok_ctrl_t tok_ctrl  [0:ENTRIES];
    logic [PAGE_BITS-1:0]  tok_page  [0:ENTRIES];
    logic [FRAME_BITS-1:0] tok_frame [0:ENTRIES];
    logic [IDX_W-1:0]      tok_slot  [0:ENTRIES];
    logic [COUNT_BITS-1:0] tok_low   [0:ENTRIES];

    tlb_lf_pkg::tok_ctrl_t inj_ctrl_reg, inj_ctrl_next;
    logic [PAGE_BITS-1:0]  inj_page_reg;
    logic [FRAME_BITS-1:0] inj_frame_reg;

    tlb_lf_pkg::tok_ctrl_t res_ctrl_reg;
    logic [PAGE_BITS-1:0]  res_page_reg;
    logic [FRAME_BITS-1:0] res_frame_reg;
    logic [IDX_W-1:0]      res_slot_reg;

    logic             m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0] m_tdata_reg;
    logic [31:0]      hit_total_reg, hit_total_next;

    tlb_lf_pkg::commit_t commit;

    logic accept;
    logic out_free;
    logic fire;
    logic res_hit;
    logic res_replaced;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign out_free = !m_tvalid_reg || m_tready;
    assign fire     = (state_reg == ST_COMMIT) && out_free;

    always_comb
    begin
        if (cfg_reg == '0)
        begin
            n_active = CNT_W'(1);
        end
        else if (32'(cfg_reg) > 32'(ENTRIES))
        begin
            n_active = CNT_W'(ENTRIES);
        end
        else
        begin
            n_active = CNT_W'(cfg_reg);
        end
    end

    always_comb
    begin
        inj_ctrl_next            = '0;
        inj_ctrl_next.vld        = accept;
        inj_ctrl_next.cmd        = s_tuser;
        inj_ctrl_next.wr         = s_tdata[PAGE_BITS];
    end

    assign tok_ctrl[0]  = inj_ctrl_reg;
    assign tok_page[0]  = inj_page_reg;
    assign tok_frame[0] = inj_frame_reg;
    assign tok_slot[0]  = '0;
    assign tok_low[0]   = {COUNT_BITS{1'b1}};

    assign res_hit      = (res_ctrl_reg.cmd == tlb_lf_pkg::CMD_LOOKUP) && res_ctrl_reg.found;
    assign res_replaced = (res_ctrl_reg.cmd == tlb_lf_pkg::CMD_FILL) && !res_ctrl_reg.free_found;

    always_comb
    begin
        commit.en  = fire && (res_hit || (res_ctrl_reg.cmd == tlb_lf_pkg::CMD_FILL));
        commit.cmd = res_ctrl_reg.cmd;
        commit.wr  = res_ctrl_reg.wr;
    end

    genvar g;
    generate
        for (g = 0; g < ENTRIES; g++)
        begin : g_cell
            tlb_lf_cell #(
                .IDX        (g),
                .ENTRIES    (ENTRIES),
                .PAGE_BITS  (PAGE_BITS),
                .FRAME_BITS (FRAME_BITS),
                .COUNT_BITS (COUNT_BITS)
            ) u_cell (
                .clk          (clk),
                .rst_n        (rst_n),
                .n_active     (n_active),
                .in_ctrl      (tok_ctrl[g]),
                .in_page      (tok_page[g]),
                .in_frame     (tok_frame[g]),
                .in_slot      (tok_slot[g]),
                .in_low       (tok_low[g]),
                .out_ctrl     (tok_ctrl[g+1]),
                .out_page     (tok_page[g+1]),
                .out_frame    (tok_frame[g+1]),
                .out_slot     (tok_slot[g+1]),
                .out_low      (tok_low[g+1]),
                .commit       (commit),
                .commit_slot  (res_slot_reg),
                .commit_page  (res_page_reg),
                .commit_frame (res_frame_reg)
            );
        end
    endgenerate

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_SWEEP;
                end
            end
            ST_SWEEP:
            begin
                if (tok_ctrl[ENTRIES].vld)
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        hit_total_next = hit_total_reg;
        if (fire && res_hit)
        begin
            hit_total_next = hit_total_reg + 32'd1;
        end
    end

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (fire)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cfg_reg       <= tlb_lf_pkg::CFG_RESET;
            inj_ctrl_reg  <= '0;
            res_ctrl_reg  <= '0;
            m_tvalid_reg  <= 1'b0;
            hit_total_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            inj_ctrl_reg  <= inj_ctrl_next;
            m_tvalid_reg  <= m_tvalid_next;
            hit_total_reg <= hit_total_next;
            if (cfg_we)
            begin
                cfg_reg <= cfg_wdata;
            end
            if ((state_reg == ST_SWEEP) && tok_ctrl[ENTRIES].vld)
            begin
                res_ctrl_reg <= tok_ctrl[ENTRIES];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            inj_page_reg <= s_tdata[PAGE_BITS-1:0];
            if (s_tuser == tlb_lf_pkg::CMD_FILL)
            begin
                inj_frame_reg <= s_tdata[PAGE_BITS+FRAME_BITS:PAGE_BITS+1];
            end
            else
            begin
                inj_frame_reg <= '0;
            end
        end
        if ((state_reg == ST_SWEEP) && tok_ctrl[ENTRIES].vld)
        begin
            res_page_reg  <= tok_page[ENTRIES];
            res_frame_reg <= tok_frame[ENTRIES];
            res_slot_reg  <= tok_slot[ENTRIES];
        end
        if (fire)
        begin
            m_tdata_reg <= OUT_W'({hit_total_next, res_replaced, res_slot_reg,
                                   res_frame_reg, res_hit});
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

### bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    localparam int SLOTS       = tlb_lf_pkg::ENTRIES_DEF;
    localparam int SLOT_W      = $clog2(SLOTS);
    localparam int PAGE_W      = tlb_lf_pkg::PAGE_BITS_DEF;
    localparam int FRAME_W     = tlb_lf_pkg::FRAME_BITS_DEF;
    localparam int USE_W       = tlb_lf_pkg::COUNT_BITS_DEF;
    localparam int CFG_W       = tlb_lf_pkg::CFG_W;
    localparam int IN_W        = 48;
    localparam int OUT_W       = 64;
    localparam int CYCLE_LIMIT = 600000;
    localparam int HOLD_CYCLES = 400;
    localparam int HOLD_AT     = 150;
    localparam int MAX_REPORTS = 100;

    localparam logic [USE_W-1:0]   USE_MAX   = '1;
    localparam logic [PAGE_W-1:0]  PAGE_TOP  = '1;
    localparam logic [FRAME_W-1:0] FRAME_TOP = '1;

    typedef struct packed {
        logic               cmd;
        logic [PAGE_W-1:0]  page;
        logic               wr;
        logic [FRAME_W-1:0] fill_frame;
    } tlb_request_t;

    // Members are listed from the highest bit down to match the result bus.
    typedef struct packed {
        logic [31:0]        hits;
        logic               replaced;
        logic [SLOT_W-1:0]  slot;
        logic [FRAME_W-1:0] frame;
        logic               hit;
    } tlb_answer_t;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             cfg_we    = 1'b0;
    logic [CFG_W-1:0] cfg_wdata = '0;
    logic             s_tvalid  = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata   = '0;
    logic             s_tuser   = 1'b0;
    logic             m_tvalid;
    logic             m_tready  = 1'b0;
    logic [OUT_W-1:0] m_tdata;

    tlb_request_t pending_requests [$];
    tlb_answer_t  awaited_answers [$];
    tlb_request_t on_bus;
    tlb_answer_t  seen_answer;
    tlb_answer_t  due_answer;

    logic               slot_valid [SLOTS];
    logic [PAGE_W-1:0]  slot_page [SLOTS];
    logic [FRAME_W-1:0] slot_frame [SLOTS];
    logic               slot_dirty [SLOTS];
    logic [USE_W-1:0]   slot_uses [SLOTS];
    logic [31:0]        hit_total;
    logic [CFG_W-1:0]   entry_count_cfg;

    int mismatches    = 0;
    int cycle_count   = 0;
    int burst_left    = 0;
    int gap_left      = 0;
    int answers_taken = 0;
    int hold_left     = 0;
    int stall_phase   = 0;
    int stall_mode    = 0;
    logic hold_done   = 1'b0;

    tlb_lookup_fill_lfu u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #10 clk = ~clk;

    function automatic tlb_answer_t translate_request(input tlb_request_t req);
        tlb_answer_t      ans;
        int               active;
        int               victim;
        logic             done;
        logic [USE_W-1:0] lowest;
        ans    = '0;
        done   = 1'b0;
        active = (entry_count_cfg == 0) ? 1 :
                 (entry_count_cfg > SLOTS) ? SLOTS : int'(entry_count_cfg);
        if (req.cmd == tlb_lf_pkg::CMD_LOOKUP)
        begin
            for (int i = 0; i < active; i++)
            begin
                if (!done && slot_valid[i] && slot_page[i] == req.page)
                begin
                    done      = 1'b1;
                    ans.hit   = 1'b1;
                    ans.frame = slot_frame[i];
                    ans.slot  = SLOT_W'(i);
                    if (slot_uses[i] != USE_MAX)
                        slot_uses[i] = slot_uses[i] + 1'b1;
                    if (req.wr)
                        slot_dirty[i] = 1'b1;
                    hit_total = hit_total + 32'd1;
                end
            end
        end
        else
        begin
            victim = 0;
            lowest = slot_uses[0];
            for (int i = 0; i < active; i++)
            begin
                if (!done)
                begin
                    if (!slot_valid[i])
                    begin
                        victim = i;
                        done   = 1'b1;
                    end
                    else if (slot_uses[i] < lowest)
                    begin
                        lowest = slot_uses[i];
                        victim = i;
                    end
                end
            end
            ans.replaced       = !done;
            slot_valid[victim] = 1'b1;
            slot_page[victim]  = req.page;
            slot_frame[victim] = req.fill_frame;
            slot_dirty[victim] = req.wr;
            slot_uses[victim]  = '0;
            ans.frame          = req.fill_frame;
            ans.slot           = SLOT_W'(victim);
        end
        ans.hits = hit_total;
        return ans;
    endfunction

    task automatic report_field(input string field, input logic [31:0] due,
                                input logic [31:0] seen);
        if (due !== seen)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: %s expected 0x%0h, got 0x%0h", $time, field, due, seen);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                awaited_answers.push_back(translate_request(on_bus));
            if (!s_tvalid || s_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end
                else if (pending_requests.size() > 0)
                begin
                    on_bus   = pending_requests.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {7'b0, on_bus.fill_frame, on_bus.wr, on_bus.page};
                    s_tuser  <= on_bus.cmd;
                    if (burst_left > 0)
                        burst_left--;
                    if (burst_left == 0)
                    begin
                        burst_left = $urandom_range(1, 16);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
                    end
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                answers_taken++;
                seen_answer = tlb_answer_t'(m_tdata[57:0]);
                if (awaited_answers.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: no answer expected, got 0x%0h", $time, m_tdata);
                end
                else
                begin
                    due_answer = awaited_answers.pop_front();
                    report_field("hit", 32'(due_answer.hit), 32'(seen_answer.hit));
                    report_field("frame", 32'(due_answer.frame), 32'(seen_answer.frame));
                    report_field("slot", 32'(due_answer.slot), 32'(seen_answer.slot));
                    report_field("replaced_valid", 32'(due_answer.replaced),
                                 32'(seen_answer.replaced));
                    report_field("hits_so_far", due_answer.hits, seen_answer.hits);
                end
                if (answers_taken == HOLD_AT && !hold_done)
                begin
                    hold_done = 1'b1;
                    hold_left = HOLD_CYCLES;
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                if (stall_phase == 0)
                begin
                    stall_mode  = $urandom_range(0, 3);
                    stall_phase = $urandom_range(20, 120);
                end
                else
                begin
                    stall_phase--;
                end
                case (stall_mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 3) != 0);
                    2: m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= stall_phase[1];
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic queue_request(input logic cmd, input logic [PAGE_W-1:0] page,
                                 input logic wr, input logic [FRAME_W-1:0] frame);
        tlb_request_t req;
        req.cmd        = cmd;
        req.page       = page;
        req.wr         = wr;
        req.fill_frame = frame;
        pending_requests.push_back(req);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        while (pending_requests.size() != 0 || s_tvalid || awaited_answers.size() != 0)
            @(negedge clk);
        repeat (SLOTS + 4) @(negedge clk);
    endtask

    task automatic set_entry_count(input logic [CFG_W-1:0] value);
        wait_idle();
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        entry_count_cfg = value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Most requests use a small page pool so that hits, duplicates and evictions are common.
    task automatic run_random_phase(input logic [CFG_W-1:0] count_value, input int item_total);
        logic [PAGE_W-1:0] pool [SLOTS + 4];
        logic [PAGE_W-1:0] pg;
        int                pool_size;
        int                queued;
        int                pick;
        set_entry_count(count_value);
        pool_size = (count_value == 0) ? 5 :
                    (count_value > SLOTS) ? SLOTS + 4 : int'(count_value) + 4;
        for (int i = 0; i < pool_size; i++)
            pool[i] = PAGE_W'($urandom);
        queued = 0;
        while (queued < item_total)
        begin
            pick = $urandom_range(0, 99);
            pg   = pool[$urandom_range(0, pool_size - 1)];
            if (pick < 15)
            begin
                queue_request(tlb_lf_pkg::CMD_LOOKUP, pg, 1'($urandom_range(0, 1)),
                              FRAME_W'($urandom));
                queue_request(tlb_lf_pkg::CMD_FILL, pg, 1'($urandom_range(0, 1)),
                              FRAME_W'($urandom));
                queue_request(tlb_lf_pkg::CMD_LOOKUP, pg, 1'($urandom_range(0, 1)),
                              FRAME_W'($urandom));
                queued += 3;
            end
            else
            begin
                if (pick < 55)
                    queue_request(tlb_lf_pkg::CMD_LOOKUP, pg, 1'($urandom_range(0, 1)),
                                  FRAME_W'($urandom));
                else if (pick < 85)
                    queue_request(tlb_lf_pkg::CMD_FILL, pg, 1'($urandom_range(0, 1)),
                                  FRAME_W'($urandom));
                else
                    queue_request($urandom_range(0, 1) ? tlb_lf_pkg::CMD_FILL
                                                       : tlb_lf_pkg::CMD_LOOKUP,
                                  PAGE_W'($urandom), 1'($urandom_range(0, 1)),
                                  FRAME_W'($urandom));
                queued++;
            end
        end
    endtask

    initial
    begin
        logic [PAGE_W-1:0] hot_page;
        for (int i = 0; i < SLOTS; i++)
        begin
            slot_valid[i] = 1'b0;
            slot_page[i]  = '0;
            slot_frame[i] = '0;
            slot_dirty[i] = 1'b0;
            slot_uses[i]  = '0;
        end
        hit_total       = '0;
        entry_count_cfg = tlb_lf_pkg::CFG_RESET;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);

        // Misses on an empty buffer, extreme pages and frames, a duplicate fill.
        queue_request(tlb_lf_pkg::CMD_LOOKUP, '0, 1'b0, '0);
        queue_request(tlb_lf_pkg::CMD_LOOKUP, PAGE_TOP, 1'b1, FRAME_TOP);
        queue_request(tlb_lf_pkg::CMD_FILL, '0, 1'b1, FRAME_TOP);
        queue_request(tlb_lf_pkg::CMD_FILL, PAGE_TOP, 1'b0, '0);
        queue_request(tlb_lf_pkg::CMD_LOOKUP, PAGE_TOP, 1'b1, '0);
        queue_request(tlb_lf_pkg::CMD_LOOKUP, '0, 1'b0, FRAME_TOP);
        queue_request(tlb_lf_pkg::CMD_FILL, '0, 1'b0, 20'h12345);
        queue_request(tlb_lf_pkg::CMD_LOOKUP, '0, 1'b1, '0);
        queue_request(tlb_lf_pkg::CMD_LOOKUP, 20'h55555, 1'b1, 20'hAAAAA);

        // Two slots searched: the less used one is evicted.
        set_entry_count(5'd2);
        queue_request(tlb_lf_pkg::CMD_FILL, 20'hAAAAA, 1'b1, 20'h55555);

        // A count of zero searches slot 0 only; the other slots keep their contents.
        set_entry_count(5'd0);
        queue_request(tlb_lf_pkg::CMD_FILL, 20'h0F0F0, 1'b0, 20'hF0F0F);
        queue_request(tlb_lf_pkg::CMD_LOOKUP, 20'hAAAAA, 1'b0, '0);

        set_entry_count(5'd31);
        queue_request(tlb_lf_pkg::CMD_LOOKUP, 20'hAAAAA, 1'b0, '0);
        queue_request(tlb_lf_pkg::CMD_LOOKUP, '0, 1'b1, '0);

        // One slot hammered until its use count saturates.
        set_entry_count(5'd1);
        hot_page = PAGE_W'($urandom);
        queue_request(tlb_lf_pkg::CMD_FILL, hot_page, 1'($urandom_range(0, 1)),
                      FRAME_W'($urandom));
        for (int i = 0; i < 289; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                queue_request(tlb_lf_pkg::CMD_LOOKUP, PAGE_W'($urandom),
                              1'($urandom_range(0, 1)), FRAME_W'($urandom));
            else
                queue_request(tlb_lf_pkg::CMD_LOOKUP, hot_page, 1'($urandom_range(0, 1)),
                              FRAME_W'($urandom));
        end

        run_random_phase(5'd2, 75);
        run_random_phase(5'd16, 75);
        run_random_phase(5'd0, 75);
        run_random_phase(5'd31, 75);
        run_random_phase(5'd3, 75);
        run_random_phase(5'd17, 75);
        run_random_phase(5'd8, 75);
        run_random_phase(5'd5, 75);
        run_random_phase(5'd12, 75);
        run_random_phase(5'd16, 75);

        wait_idle();
        repeat (40) @(negedge clk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

### files.f
sv/tlb_lf_pkg.sv
sv/tlb_lf_cell.sv
sv/tlb_lookup_fill_lfu.sv
bench/tb_top.sv
